>>> rtl/tsf_pkg.sv
// Shared types and constants for the textured span texel fetch block.
// Holds the channel payloads, the item codes and the texel address function.
// Depends on nothing; every other source file but tsf_queue imports it.
package tsf_pkg;

  typedef enum logic [1:0] {
    MODE_TEXEL   = 2'd0,
    MODE_PALETTE = 2'd1,
    MODE_DRAW    = 2'd2
  } mode_t;

  localparam logic [1:0] REG_WIDTH_LOG2    = 2'd0;
  localparam logic [1:0] REG_HEIGHT_LOG2   = 2'd1;
  localparam logic [1:0] REG_PALETTED_MODE = 2'd2;

  localparam int CountBits = 7;
  localparam int Log2Bits  = 5;
  localparam logic [Log2Bits-1:0] Log2Max = 5'd16;

  typedef struct packed {
    logic [1:0]           mode;
    logic [15:0]          load_index;
    logic [31:0]          load_value;
    logic                 load_alpha;
    logic [31:0]          u_start;
    logic [31:0]          v_start;
    logic [31:0]          u_step;
    logic [31:0]          v_step;
    logic [CountBits-1:0] pixel_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic        write_enable;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    mode_t                kind;
    logic [15:0]          index;
    logic [31:0]          value;
    logic                 alpha;
    logic [31:0]          u;
    logic [31:0]          v;
    logic [31:0]          du;
    logic [31:0]          dv;
    logic [CountBits-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [Log2Bits-1:0] u_bits;
    logic [Log2Bits-1:0] v_bits;
    logic                paletted;
  } cfg_t;

  // Wrapped texel address: integer parts masked, v placed above u.
  function automatic logic [31:0] texel_addr(input logic [31:0] u, input logic [31:0] v,
                                             input logic [Log2Bits-1:0] ub,
                                             input logic [Log2Bits-1:0] vb);
    logic [16:0] um;
    logic [16:0] vm;
    logic [31:0] pu;
    logic [31:0] pv;
    um = (17'd1 << ub) - 17'd1;
    vm = (17'd1 << vb) - 17'd1;
    pu = {16'd0, u[31:16] & um[15:0]};
    pv = {16'd0, v[31:16] & vm[15:0]} << ub;
    return pu | pv;
  endfunction

endpackage

>>> rtl/tsf_in_if.sv
// Input item channel: valid, ready and one span or load item.
// Depends on tsf_pkg.
interface tsf_in_if import tsf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tsf_out_if.sv
// Result channel: valid, ready and one pixel.
// Depends on tsf_pkg.
interface tsf_out_if import tsf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tsf_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
// Depends on tsf_pkg.
interface tsf_cfg_if import tsf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          index;
  logic [Log2Bits-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/tsf_queue.sv
// Small first-in first-out queue of any packed type, with a fill level.
// Depends on nothing beyond the type handed in.
module tsf_queue #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  input  T                           push_data,
  output logic                       full,
  output logic                       pop_valid,
  output T                           pop_data,
  input  logic                       pop_ready,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  T                mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [LW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == LW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign level     = count;
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + LW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end
endmodule

>>> rtl/tsf_front.sv
// Front end: holds the configuration registers, accepts items and classifies
// them into queue entries. Depends on tsf_pkg and the channel interfaces.
module tsf_front import tsf_pkg::*; #(
  parameter int MAX_SPAN_PIXELS = 64
) (
  input  logic         clk,
  input  logic         rst,
  tsf_in_if.sink       items,
  tsf_cfg_if.sink      cfg,
  output logic         q_push,
  output entry_t       q_entry,
  input  logic         q_full,
  output cfg_t         cfg_state
);
  logic [Log2Bits-1:0]  width_log2;
  logic [Log2Bits-1:0]  height_log2;
  logic                 paletted_mode;
  logic                 is_load;
  logic                 is_draw;
  logic [CountBits-1:0] count_sat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2    <= Log2Bits'(8);
      height_log2   <= Log2Bits'(8);
      paletted_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_WIDTH_LOG2:    width_log2    <= cfg.wdata;
        REG_HEIGHT_LOG2:   height_log2   <= cfg.wdata;
        REG_PALETTED_MODE: paletted_mode <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg_state.u_bits   = (width_log2 > Log2Max) ? Log2Max : width_log2;
  assign cfg_state.v_bits   = (height_log2 > Log2Max) ? Log2Max : height_log2;
  assign cfg_state.paletted = paletted_mode;

  assign count_sat = (items.data.pixel_count > CountBits'(MAX_SPAN_PIXELS))
                     ? CountBits'(MAX_SPAN_PIXELS) : items.data.pixel_count;

  assign is_load = (items.data.mode == MODE_TEXEL) || (items.data.mode == MODE_PALETTE);
  assign is_draw = (items.data.mode == MODE_DRAW) && (count_sat != '0);

  assign items.ready = !q_full;
  assign q_push      = items.valid && !q_full && (is_load || is_draw);

  always_comb begin
    q_entry.kind  = mode_t'(items.data.mode);
    q_entry.index = items.data.load_index;
    q_entry.value = items.data.load_value;
    q_entry.alpha = items.data.load_alpha;
    q_entry.u     = items.data.u_start;
    q_entry.v     = items.data.v_start;
    q_entry.du    = items.data.u_step;
    q_entry.dv    = items.data.v_step;
    q_entry.count = count_sat;
  end
endmodule

>>> rtl/tsf_back.sv
// Back end: performs loads into the texel and palette memories and walks
// spans through a texel read, a palette read and an output queue.
// Depends on tsf_pkg, tsf_queue and the result channel interface.
module tsf_back import tsf_pkg::*; #(
  parameter int TEXEL_ADDR_BITS = 16,
  parameter int MAX_SPAN_PIXELS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  entry_t   q_entry,
  output logic     q_pop,
  input  cfg_t     cfg_state,
  tsf_out_if.source pixels
);
  localparam int TexDepth = 1 << TEXEL_ADDR_BITS;
  localparam int CW       = $clog2(MAX_SPAN_PIXELS + 1);
  localparam int OutDepth = 4;
  localparam int LW       = $clog2(OutDepth + 1);

  typedef enum logic {ST_IDLE, ST_SPAN} state_t;

  state_t                     state;
  logic [31:0]                u;
  logic [31:0]                v;
  logic [31:0]                du;
  logic [31:0]                dv;
  logic [CW-1:0]              remaining;
  logic                       issue;
  logic                       issue_last;
  logic [31:0]                addr_full;
  logic [TEXEL_ADDR_BITS-1:0] tex_raddr;
  logic [31:0]                widx;
  logic                       tex_we;
  logic                       pal_we;
  logic [31:0]                tex_mem [TexDepth];
  logic [32:0]                pal_mem [256];
  logic [31:0]                texel_q;
  logic [32:0]                pal_q;
  logic                       p1_valid;
  logic                       p1_last;
  logic                       p2_valid;
  logic                       p2_last;
  logic [31:0]                p2_texel;
  logic [LW-1:0]              out_level;
  logic [LW:0]                occupancy;
  out_item_t                  result;

  assign q_pop  = (state == ST_IDLE);
  assign tex_we = q_pop && q_valid && (q_entry.kind == MODE_TEXEL);
  assign pal_we = q_pop && q_valid && (q_entry.kind == MODE_PALETTE);
  assign widx   = {16'd0, q_entry.index};

  assign addr_full  = texel_addr(u, v, cfg_state.u_bits, cfg_state.v_bits);
  assign tex_raddr  = addr_full[TEXEL_ADDR_BITS-1:0];
  assign occupancy  = (LW+1)'(out_level) + (LW+1)'(p1_valid) + (LW+1)'(p2_valid);
  assign issue      = (state == ST_SPAN) && (occupancy < (LW+1)'(OutDepth));
  assign issue_last = (remaining == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
      p1_valid  <= 1'b0;
      p1_last   <= 1'b0;
      p2_valid  <= 1'b0;
      p2_last   <= 1'b0;
    end else begin
      p1_valid <= issue;
      p1_last  <= issue && issue_last;
      p2_valid <= p1_valid;
      p2_last  <= p1_last;
      case (state)
        ST_IDLE: begin
          if (q_valid && (q_entry.kind == MODE_DRAW)) begin
            u         <= q_entry.u;
            v         <= q_entry.v;
            du        <= q_entry.du;
            dv        <= q_entry.dv;
            remaining <= q_entry.count[CW-1:0];
            state     <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          if (issue) begin
            u         <= u + du;
            v         <= v + dv;
            remaining <= remaining - CW'(1);
            if (issue_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tex_we) begin
      tex_mem[widx[TEXEL_ADDR_BITS-1:0]] <= q_entry.value;
    end
    texel_q <= tex_mem[tex_raddr];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[q_entry.index[7:0]] <= {q_entry.alpha, q_entry.value};
    end
    pal_q    <= pal_mem[texel_q[7:0]];
    p2_texel <= texel_q;
  end

  always_comb begin
    result.last_pixel = p2_last;
    if (cfg_state.paletted) begin
      result.write_enable = pal_q[32];
      result.pixel_color  = pal_q[32] ? pal_q[31:0] : 32'd0;
    end else begin
      result.write_enable = 1'b1;
      result.pixel_color  = p2_texel;
    end
  end

  tsf_queue #(
    .T     (out_item_t),
    .DEPTH (OutDepth)
  ) u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (p2_valid),
    .push_data  (result),
    .full       (),
    .pop_valid  (pixels.valid),
    .pop_data   (pixels.data),
    .pop_ready  (pixels.ready),
    .level      (out_level)
  );
endmodule

>>> rtl/textured_span_texel_fetch.sv
// Top level of the textured span texel fetch block: front end, item queue
// and back end. Depends on tsf_pkg, the channel interfaces, tsf_queue,
// tsf_front and tsf_back.
//
// Load items write one texel word or one palette entry each in the back end.
// A draw item is popped from the item queue and then delivers one pixel per
// cycle while the output queue has room and results are taken; the single
// read port of the texel memory sets that rate. After its texel read is
// issued, a pixel passes the texel and palette read registers and then the
// four-entry output queue, which keeps the pixel stream running while the
// consumer briefly holds ready low. A two-entry item queue lets the front
// end keep accepting items during a span.
module textured_span_texel_fetch import tsf_pkg::*; #(
  parameter int TEXEL_ADDR_BITS = 16,
  parameter int MAX_SPAN_PIXELS = 64
) (
  input  logic      clk,
  input  logic      rst,
  tsf_in_if.sink    items,
  tsf_cfg_if.sink   cfg,
  tsf_out_if.source pixels
);
  logic   q_push;
  entry_t q_entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_head;
  logic   q_pop;
  cfg_t   cfg_state;

  tsf_front #(
    .MAX_SPAN_PIXELS (MAX_SPAN_PIXELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg       (cfg),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_full    (q_full),
    .cfg_state (cfg_state)
  );

  tsf_queue #(
    .T     (entry_t),
    .DEPTH (2)
  ) u_item_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push),
    .push_data  (q_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_data   (q_head),
    .pop_ready  (q_pop),
    .level      ()
  );

  tsf_back #(
    .TEXEL_ADDR_BITS (TEXEL_ADDR_BITS),
    .MAX_SPAN_PIXELS (MAX_SPAN_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .cfg_state (cfg_state),
    .pixels    (pixels)
  );
endmodule

>>> dv/tb_textured_span_texel_fetch.sv
// Self-checking testbench for textured_span_texel_fetch: random-stall beats on the item
// and pixel channels, with an in-bench predictor of the texel store, palette and span walk.
// Depends on tsf_pkg, the three channel interfaces and the block's RTL.
module tb_textured_span_texel_fetch import tsf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_PIXELS   = 64;
  localparam int RANDOM_ITEMS = 350;
  localparam int SETTLE       = 16;
  localparam int TAIL         = 32;
  localparam int STALL_LIMIT  = 3000;
  localparam int REPORT_CAP   = 100;

  logic clk;
  logic rst;

  tsf_in_if  items_if ();
  tsf_cfg_if cfg_if ();
  tsf_out_if pix_if ();

  textured_span_texel_fetch uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .cfg    (cfg_if),
    .pixels (pix_if)
  );

  logic [31:0] tex_mem [0:65535];
  bit          tex_written [0:65535];
  logic [31:0] pal_color [0:255];
  logic        pal_alpha [0:255];
  bit          pal_written [0:255];
  logic [4:0]  cur_w;
  logic [4:0]  cur_h;
  logic        cur_pal;

  out_item_t expected_pixels [$];
  bit steady;
  int errors;
  int items_sent;
  int spans_sent;
  int ignored_sent;
  int pixels_checked;
  int cfg_writes;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] wrap_addr(logic [31:0] u, logic [31:0] v);
    int unsigned ub;
    int unsigned vb;
    logic [63:0] um;
    logic [63:0] vm;
    logic [63:0] a;
    ub = (cur_w > 5'd16) ? 16 : cur_w;
    vb = (cur_h > 5'd16) ? 16 : cur_h;
    um = (64'd1 << ub) - 64'd1;
    vm = (64'd1 << vb) - 64'd1;
    a = ({48'd0, u[31:16]} & um) | (({48'd0, v[31:16]} & vm) << ub);
    return a[15:0];
  endfunction

  function automatic void predict_pixels(in_item_t it);
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] texel;
    out_item_t px;
    int n;
    int i;
    case (it.mode)
      MODE_TEXEL: begin
        tex_mem[it.load_index] = it.load_value;
        tex_written[it.load_index] = 1'b1;
      end
      MODE_PALETTE: begin
        pal_color[it.load_index[7:0]] = it.load_value;
        pal_alpha[it.load_index[7:0]] = it.load_alpha;
        pal_written[it.load_index[7:0]] = 1'b1;
      end
      MODE_DRAW: begin
        n = (it.pixel_count > MAX_PIXELS) ? MAX_PIXELS : it.pixel_count;
        u = it.u_start;
        v = it.v_start;
        for (i = 0; i < n; i++) begin
          texel = tex_mem[wrap_addr(u, v)];
          px.pixel_color = texel;
          px.write_enable = 1'b1;
          if (cur_pal) begin
            if (pal_alpha[texel[7:0]]) begin
              px.pixel_color = pal_color[texel[7:0]];
            end else begin
              px.pixel_color = 32'd0;
              px.write_enable = 1'b0;
            end
          end
          px.last_pixel = (i == n - 1);
          expected_pixels.push_back(px);
          u += it.u_step;
          v += it.v_step;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode        = MODE_UNUSED;
    it.load_index  = 16'($urandom);
    it.load_value  = $urandom;
    it.load_alpha  = 1'($urandom_range(0, 1));
    it.u_start     = $urandom;
    it.v_start     = $urandom;
    it.u_step      = $urandom;
    it.v_step      = $urandom;
    it.pixel_count = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic logic [31:0] rand_step();
    logic [31:0] s;
    case ($urandom_range(0, 3))
      0: s = $urandom;
      1: s = $urandom_range(0, 32'h0003_0000);
      2: s = 32'd0 - $urandom_range(0, 32'h0003_0000);
      default: s = 32'h0001_0000;
    endcase
    return s;
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 21) begin
      items_if.valid <= 1'b0;
      @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    predict_pixels(it);
    if (it.mode == MODE_UNUSED) ignored_sent++;
    else items_sent++;
    if (it.mode == MODE_DRAW) spans_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    items_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    wait_idle();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_WIDTH_LOG2:    cur_w = val;
      REG_HEIGHT_LOG2:   cur_h = val;
      REG_PALETTED_MODE: cur_pal = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_texel(input logic [15:0] addr, input logic [31:0] val);
    in_item_t it;
    it = random_item();
    it.mode = MODE_TEXEL;
    it.load_index = addr;
    it.load_value = val;
    send_item(it);
  endtask

  task automatic load_palette(input logic [7:0] idx, input logic [31:0] color, input logic alpha);
    in_item_t it;
    it = random_item();
    it.mode = MODE_PALETTE;
    it.load_index[7:0] = idx;
    it.load_value = color;
    it.load_alpha = alpha;
    send_item(it);
  endtask

  task automatic send_ignored();
    in_item_t it;
    it = random_item();
    it.mode = MODE_UNUSED;
    send_item(it);
  endtask

  // Every texel and palette entry the span will touch is loaded first.
  task automatic draw(input logic [31:0] u, input logic [31:0] v, input logic [31:0] du,
                      input logic [31:0] dv, input logic [6:0] count);
    in_item_t it;
    logic [31:0] pu;
    logic [31:0] pv;
    logic [31:0] val;
    logic [15:0] a;
    int n;
    int i;
    n = (count > MAX_PIXELS) ? MAX_PIXELS : count;
    pu = u;
    pv = v;
    for (i = 0; i < n; i++) begin
      a = wrap_addr(pu, pv);
      if (!tex_written[a]) begin
        val = $urandom;
        if (cur_pal && $urandom_range(0, 1)) val[7:0] = 8'($urandom_range(0, 15));
        load_texel(a, val);
      end
      if (cur_pal && !pal_written[tex_mem[a][7:0]])
        load_palette(tex_mem[a][7:0], $urandom, $urandom_range(0, 3) != 0);
      pu += du;
      pv += dv;
    end
    it = random_item();
    it.mode = MODE_DRAW;
    it.u_start = u;
    it.v_start = v;
    it.u_step = du;
    it.v_step = dv;
    it.pixel_count = count;
    send_item(it);
  endtask

  task automatic test_direct_extremes();
    load_texel(16'h0000, 32'h0000_0000);
    load_texel(16'hFFFF, 32'hFFFF_FFFF);
    draw(32'd0, 32'd0, 32'd0, 32'd0, 7'd1);
    draw(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 7'd2);
    draw($urandom, $urandom, $urandom, $urandom, 7'd0);
    send_ignored();
  endtask

  task automatic test_log2_extremes();
    write_reg(REG_WIDTH_LOG2, 5'd0);
    write_reg(REG_HEIGHT_LOG2, 5'd0);
    draw($urandom, $urandom, $urandom, $urandom, 7'd127);
    write_reg(REG_WIDTH_LOG2, 5'd16);
    draw($urandom, $urandom, 32'h0001_0000, $urandom, 7'd4);
    write_reg(REG_WIDTH_LOG2, 5'd31);
    write_reg(REG_HEIGHT_LOG2, 5'd31);
    draw($urandom, $urandom, $urandom, $urandom, 7'd3);
    write_reg(REG_WIDTH_LOG2, 5'd0);
    write_reg(REG_HEIGHT_LOG2, 5'd16);
    draw($urandom, $urandom, $urandom, 32'h0001_0000, 7'd3);
  endtask

  task automatic test_paletted();
    write_reg(REG_WIDTH_LOG2, 5'd2);
    write_reg(REG_HEIGHT_LOG2, 5'd2);
    write_reg(REG_PALETTED_MODE, 5'd1);
    load_palette(8'h00, 32'hFFFF_FFFF, 1'b1);
    load_palette(8'hFF, $urandom, 1'b0);
    load_texel(16'd0, 32'h1234_5600);
    load_texel(16'd1, 32'hABCD_EFFF);
    draw(32'd0, 32'd0, 32'h0001_0000, 32'd0, 7'd4);
    write_reg(REG_PALETTED_MODE, 5'd0);
  endtask

  task automatic test_back_to_back();
    write_reg(REG_WIDTH_LOG2, 5'd3);
    write_reg(REG_HEIGHT_LOG2, 5'd1);
    steady = 1'b1;
    repeat (4) draw($urandom, $urandom, rand_step(), rand_step(), 7'd64);
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_random_spans();
    int start;
    int r;
    bit big;
    logic [6:0] count;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      big = ($urandom_range(0, 5) == 0);
      write_reg(REG_WIDTH_LOG2, big ? 5'($urandom_range(12, 31)) : 5'($urandom_range(0, 4)));
      write_reg(REG_HEIGHT_LOG2, big ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4)));
      write_reg(REG_PALETTED_MODE, 5'($urandom_range(0, 1)));
      repeat ($urandom_range(15, 40)) begin
        if (items_sent - start >= RANDOM_ITEMS) break;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          r = $urandom_range(0, 19);
          if (big) count = 7'($urandom_range(0, 6));
          else if (r < 2) count = 7'd64;
          else if (r == 2) count = 7'($urandom_range(65, 127));
          else count = 7'($urandom_range(0, 16));
          draw($urandom, $urandom, rand_step(), rand_step(), count);
        end else if (r < 84) begin
          load_texel(16'($urandom), $urandom);
        end else if (r < 95) begin
          load_palette(8'($urandom), $urandom, 1'($urandom_range(0, 1)));
        end else begin
          send_ignored();
        end
      end
    end
  endtask

  always @(negedge clk) pix_if.ready <= steady || ($urandom_range(0, 99) >= 21);

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pix_if.valid && pix_if.ready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors < REPORT_CAP)
          $display("%0t: pixel beat with none expected, actual %h", $time, pix_if.data);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (want.pixel_color !== pix_if.data.pixel_color) begin
          errors++;
          if (errors < REPORT_CAP)
            $display("%0t: pixel_color expected %h actual %h", $time,
                     want.pixel_color, pix_if.data.pixel_color);
        end
        if (want.write_enable !== pix_if.data.write_enable) begin
          errors++;
          if (errors < REPORT_CAP)
            $display("%0t: write_enable expected %b actual %b", $time,
                     want.write_enable, pix_if.data.write_enable);
        end
        if (want.last_pixel !== pix_if.data.last_pixel) begin
          errors++;
          if (errors < REPORT_CAP)
            $display("%0t: last_pixel expected %b actual %b", $time,
                     want.last_pixel, pix_if.data.last_pixel);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (pix_if.valid && pix_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired with no beat for %0d cycles, %0d pixels outstanding",
               $time, idle_cycles, expected_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    steady = 1'b0;
    items_if.valid = 1'b0;
    items_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_WIDTH_LOG2;
    cfg_if.wdata = '0;
    pix_if.ready = 1'b0;
    idle_cycles = 0;
    cur_w = 5'd8;
    cur_h = 5'd8;
    cur_pal = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_direct_extremes();
    test_log2_extremes();
    test_paletted();
    test_back_to_back();
    test_random_spans();

    wait_idle();
    repeat (TAIL) @(posedge clk);
    $display("Sent %0d load and span items (%0d spans) plus %0d ignored items, %0d register writes.",
             items_sent, spans_sent, ignored_sent, cfg_writes);
    $display("Compared %0d pixels across direct and paletted modes and texture sizes 1 to 2^16.",
             pixels_checked);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tsf_pkg.sv
rtl/tsf_in_if.sv
rtl/tsf_out_if.sv
rtl/tsf_cfg_if.sv
rtl/tsf_queue.sv
rtl/tsf_front.sv
rtl/tsf_back.sv
rtl/textured_span_texel_fetch.sv
dv/tb_textured_span_texel_fetch.sv
